// ===== hw/rtl/hrlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_pkg
// Types and constants shared by the request line parser and its checker.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    typedef enum logic [7:0] {
        PH_METHOD = 8'b0000_0001,
        PH_PATH   = 8'b0000_0010,
        PH_QUERY  = 8'b0000_0100,
        PH_LIT    = 8'b0000_1000,
        PH_MAJOR  = 8'b0001_0000,
        PH_DOT    = 8'b0010_0000,
        PH_MINOR  = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } t_phase;

    localparam int NUM_NAMES = 8;
    localparam logic [2:0] LIT_LEN = 3'd6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] METHOD_UNKNOWN = 4'd0;
    localparam logic [3:0] METHOD_MAX     = 4'd8;
    localparam logic [3:0] DIGIT_MAX      = 4'd9;

    // names right-justified, first character in the highest used byte
    localparam logic [63:0] NAME_TEXT [NUM_NAMES] = '{
        64'("OPTIONS"), 64'("GET"), 64'("POST"), 64'("HEAD"),
        64'("TRACE"), 64'("PUT"), 64'("DELETE"), 64'("CONNECT")
    };
    localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
        3'd7, 3'd3, 3'd4, 3'd4, 3'd5, 3'd3, 3'd6, 3'd7
    };
    localparam logic [47:0] VERSION_LIT = " HTTP/";

    typedef struct packed {
        logic        line_valid;
        logic [3:0]  method_code;
        logic [12:0] method_length;
        logic [11:0] path_start;
        logic [12:0] path_length;
        logic        query_present;
        logic [11:0] query_start;
        logic [12:0] query_length;
        logic [12:0] uri_length;
        logic [3:0]  version_major;
        logic [3:0]  version_minor;
    } t_line_result;

    // character idx of method name k; only meaningful for idx below its length
    function automatic logic [7:0] name_char(input logic [2:0] k, input logic [2:0] idx);
        logic [2:0] pos;
        pos = NAME_LEN[k] - 3'd1 - idx;
        return NAME_TEXT[k][{pos, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] lit_char(input logic [2:0] idx);
        logic [2:0] pos;
        pos = LIT_LEN - 3'd1 - idx;
        return VERSION_LIT[{pos, 3'b000} +: 8];
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

endpackage

// ===== hw/rtl/hrlp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_core
// Per-byte grammar state and the line result computed on the final byte.
// ----------------------------------------------------------------------------
module hrlp_core import hrlp_pkg::*; #(
    parameter int MAX_LINE = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_byte,
    input  logic         i_last,
    output t_line_result o_result
);

    localparam int POS_W = $clog2(MAX_LINE + 1);

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [NUM_NAMES-1:0] r_cand, n_cand;
    logic [POS_W-1:0]   r_method_count, n_method_count;
    logic [POS_W-1:0]   r_path_count, n_path_count;
    logic               r_has_query, n_has_query;
    logic [POS_W-1:0]   r_query_count, n_query_count;
    logic [2:0]         r_lit_idx, n_lit_idx;
    logic [3:0]         r_major, n_major;
    logic [3:0]         r_minor, n_minor;
    logic               r_error, n_error;

    logic [3:0]         method_code;
    logic [POS_W:0]     path_start;
    logic [POS_W+1:0]   query_start;
    logic [POS_W+1:0]   uri_len;

    always_comb begin
        n_phase        = r_phase;
        n_pos          = r_pos;
        n_cand         = r_cand;
        n_method_count = r_method_count;
        n_path_count   = r_path_count;
        n_has_query    = r_has_query;
        n_query_count  = r_query_count;
        n_lit_idx      = r_lit_idx;
        n_major        = r_major;
        n_minor        = r_minor;
        n_error        = r_error;

        if (r_pos >= POS_W'(MAX_LINE)) begin
            n_error = 1'b1;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end

        if (!n_error) begin
            unique case (r_phase)
                PH_METHOD: begin
                    if (is_alpha(i_byte)) begin
                        for (int k = 0; k < NUM_NAMES; k++) begin
                            if (!(r_method_count < POS_W'(NAME_LEN[k]) &&
                                  i_byte == name_char(3'(k), r_method_count[2:0]))) begin
                                n_cand[k] = 1'b0;
                            end
                        end
                        n_method_count = r_method_count + POS_W'(1);
                    end else if (i_byte == CH_SPACE) begin
                        n_phase = PH_PATH;
                    end else begin
                        n_error = 1'b1;
                    end
                end
                PH_PATH: begin
                    if (i_byte == CH_SPACE) begin
                        n_phase   = PH_LIT;
                        n_lit_idx = 3'd1;
                    end else if (i_byte == CH_QMARK) begin
                        n_phase     = PH_QUERY;
                        n_has_query = 1'b1;
                    end else begin
                        n_path_count = r_path_count + POS_W'(1);
                    end
                end
                PH_QUERY: begin
                    if (i_byte == CH_SPACE) begin
                        n_phase   = PH_LIT;
                        n_lit_idx = 3'd1;
                    end else begin
                        n_query_count = r_query_count + POS_W'(1);
                    end
                end
                PH_LIT: begin
                    if (r_lit_idx < LIT_LEN && i_byte == lit_char(r_lit_idx)) begin
                        n_lit_idx = r_lit_idx + 3'd1;
                        if (n_lit_idx == LIT_LEN) begin
                            n_phase = PH_MAJOR;
                        end
                    end else begin
                        n_error = 1'b1;
                    end
                end
                PH_MAJOR: begin
                    if (is_digit(i_byte)) begin
                        n_major = i_byte[3:0];
                        n_phase = PH_DOT;
                    end else begin
                        n_error = 1'b1;
                    end
                end
                PH_DOT: begin
                    if (i_byte == CH_DOT) begin
                        n_phase = PH_MINOR;
                    end else begin
                        n_error = 1'b1;
                    end
                end
                PH_MINOR: begin
                    if (is_digit(i_byte)) begin
                        n_minor = i_byte[3:0];
                        n_phase = PH_DONE;
                    end else begin
                        n_error = 1'b1;
                    end
                end
                default: begin
                    n_error = 1'b1;
                end
            endcase
        end
    end

    // result from the state after the final byte
    always_comb begin
        method_code = METHOD_UNKNOWN;
        for (int k = NUM_NAMES - 1; k >= 0; k--) begin
            if (n_cand[k] && n_method_count == POS_W'(NAME_LEN[k])) begin
                method_code = 4'(k + 1);
            end
        end
        path_start  = {1'b0, n_method_count} + (POS_W + 1)'(1);
        query_start = {1'b0, path_start} + (POS_W + 2)'(n_path_count) + (POS_W + 2)'(1);
        uri_len     = (POS_W + 2)'(n_path_count);
        if (n_has_query) begin
            uri_len = uri_len + (POS_W + 2)'(n_query_count) + (POS_W + 2)'(1);
        end

        o_result = '0;
        if (!n_error && n_phase == PH_DONE) begin
            o_result.line_valid    = 1'b1;
            o_result.method_code   = method_code;
            o_result.method_length = 13'(n_method_count);
            o_result.path_start    = 12'(path_start);
            o_result.path_length   = 13'(n_path_count);
            o_result.query_present = n_has_query;
            o_result.query_start   = n_has_query ? 12'(query_start) : 12'd0;
            o_result.query_length  = 13'(n_query_count);
            o_result.uri_length    = 13'(uri_len);
            o_result.version_major = n_major;
            o_result.version_minor = n_minor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase        <= PH_METHOD;
            r_pos          <= '0;
            r_cand         <= '1;
            r_method_count <= '0;
            r_path_count   <= '0;
            r_has_query    <= 1'b0;
            r_query_count  <= '0;
            r_lit_idx      <= 3'd0;
            r_major        <= 4'd0;
            r_minor        <= 4'd0;
            r_error        <= 1'b0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_pos          <= n_pos;
            r_cand         <= n_cand;
            r_method_count <= n_method_count;
            r_path_count   <= n_path_count;
            r_has_query    <= n_has_query;
            r_query_count  <= n_query_count;
            r_lit_idx      <= n_lit_idx;
            r_major        <= n_major;
            r_minor        <= n_minor;
            r_error        <= n_error;
        end
    end

endmodule

// ===== hw/rtl/http_request_line_parser.sv =====
`timescale 1ns / 1ps
// result: registered, on the master side in the cycle after the final byte is taken
// throughput: a byte per cycle unless stalled; the line's result register frees as taken
// s_axis_tready drops only while a result waits and m_axis_tready is low
// reset: synchronous, active low; clears the parse state and the output valid
// ----------------------------------------------------------------------------
// http_request_line_parser
// Checks one request line per frame and reports its method, URI fields and version.
// ----------------------------------------------------------------------------
module http_request_line_parser import hrlp_pkg::*; #(
    parameter int MAX_LINE = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // line_byte[7:0]
    input  logic        s_axis_tlast,   // end_of_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // method_code[3:0], method_length[16:4], path_start[28:17], path_length[41:29],
    // query_present[42], query_start[54:43], query_length[67:55], uri_length[80:68],
    // version_major[84:81], version_minor[88:85], zero fill to 95
    output logic [95:0] m_axis_tdata,
    output logic        m_axis_tuser    // line_valid
);

    logic         accept;
    t_line_result result;
    logic         r_out_valid;
    t_line_result r_out;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    hrlp_core #(
        .MAX_LINE (MAX_LINE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && s_axis_tlast) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.line_valid;
    assign m_axis_tdata  = {7'd0, r_out.version_minor, r_out.version_major,
                            r_out.uri_length, r_out.query_length, r_out.query_start,
                            r_out.query_present, r_out.path_length, r_out.path_start,
                            r_out.method_length, r_out.method_code};

endmodule

// ===== hw/rtl/hrlp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_checker
// Port-level checks of the request line parser, bound to its top level.
// ----------------------------------------------------------------------------
module hrlp_checker import hrlp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a new result only follows a final byte transaction
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (!$past(m_axis_tvalid) || $past(m_axis_tready))
        |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("result without final byte");

    // input side stalls only behind a waiting result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without cause");

    // an invalid line reports all fields zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("invalid line with nonzero fields");

    // a valid line carries a known code range and decimal version digits
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3:0] <= METHOD_MAX
        && m_axis_tdata[84:81] <= DIGIT_MAX && m_axis_tdata[88:85] <= DIGIT_MAX)
        else $error("valid line field out of range");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/http_request_line_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_parser_tb
// Streams request lines into the parser byte by byte, predicts each line's
// verdict and fields, and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module http_request_line_parser_tb;
    import hrlp_pkg::*;

    localparam int LINE_MAX    = 4096;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_BYTES = 1500;

    typedef logic [7:0] t_bytes [$];

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // line_byte[7:0]
    logic        s_axis_tlast;   // end_of_line
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // method_code[3:0], method_length[16:4], path_start[28:17], path_length[41:29],
    // query_present[42], query_start[54:43], query_length[67:55], uri_length[80:68],
    // version_major[84:81], version_minor[88:85], zero fill to 95
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;   // line_valid

    http_request_line_parser #(.MAX_LINE(LINE_MAX)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // line results predicted but not yet seen on the master side
    t_line_result expected_lines [$];

    bit idle_on;
    bit hold_req;
    int mismatches;
    int lines_checked;
    int lines_valid;
    int bytes_sent;

    // predictor copy of the parse state
    string     method_names [NUM_NAMES] = '{
        "OPTIONS", "GET", "POST", "HEAD", "TRACE", "PUT", "DELETE", "CONNECT"
    };
    string      version_text = " HTTP/";
    t_phase     p_phase;
    int         p_pos;
    logic [7:0] p_cand;
    int         p_mlen;
    int         p_plen;
    bit         p_qflag;
    int         p_qlen;
    int         p_lit;
    logic [3:0] p_major;
    logic [3:0] p_minor;
    bit         p_err;

    function automatic void clear_line_state();
        p_phase = PH_METHOD;
        p_pos   = 0;
        p_cand  = '1;
        p_mlen  = 0;
        p_plen  = 0;
        p_qflag = 1'b0;
        p_qlen  = 0;
        p_lit   = 0;
        p_major = '0;
        p_minor = '0;
        p_err   = 1'b0;
    endfunction

    function automatic bit letter(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic bit digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic void advance_grammar(input logic [7:0] b);
        case (p_phase)
            PH_METHOD: begin
                if (letter(b)) begin
                    // drop every name that no longer matches at this position
                    for (int k = 0; k < NUM_NAMES; k++) begin
                        if (!(p_mlen < method_names[k].len() && method_names[k][p_mlen] == b))
                            p_cand[k] = 1'b0;
                    end
                    p_mlen++;
                end else if (b == CH_SPACE) begin
                    p_phase = PH_PATH;
                end else begin
                    p_err = 1'b1;
                end
            end
            PH_PATH: begin
                if (b == CH_SPACE) begin
                    p_phase = PH_LIT;
                    p_lit = 1;
                end else if (b == CH_QMARK) begin
                    p_phase = PH_QUERY;
                    p_qflag = 1'b1;
                end else begin
                    p_plen++;
                end
            end
            PH_QUERY: begin
                if (b == CH_SPACE) begin
                    p_phase = PH_LIT;
                    p_lit = 1;
                end else begin
                    p_qlen++;
                end
            end
            PH_LIT: begin
                if (p_lit < LIT_LEN && version_text[p_lit] == b) begin
                    p_lit++;
                    if (p_lit == LIT_LEN) p_phase = PH_MAJOR;
                end else begin
                    p_err = 1'b1;
                end
            end
            PH_MAJOR: begin
                if (digit(b)) begin
                    p_major = 4'(b - CH_ZERO);
                    p_phase = PH_DOT;
                end else begin
                    p_err = 1'b1;
                end
            end
            PH_DOT: begin
                if (b == CH_DOT) p_phase = PH_MINOR;
                else p_err = 1'b1;
            end
            PH_MINOR: begin
                if (digit(b)) begin
                    p_minor = 4'(b - CH_ZERO);
                    p_phase = PH_DONE;
                end else begin
                    p_err = 1'b1;
                end
            end
            default: p_err = 1'b1;
        endcase
    endfunction

    function automatic void predict_line_byte(input logic [7:0] b, input logic last);
        t_line_result r;
        int pstart;
        if (p_pos >= LINE_MAX) p_err = 1'b1;
        else p_pos++;
        if (!p_err) advance_grammar(b);
        if (last) begin
            r = '0;
            if (!p_err && p_phase == PH_DONE) begin
                pstart = p_mlen + 1;
                r.line_valid    = 1'b1;
                r.method_code   = METHOD_UNKNOWN;
                for (int k = NUM_NAMES - 1; k >= 0; k--) begin
                    if (p_cand[k] && method_names[k].len() == p_mlen)
                        r.method_code = 4'(k + 1);
                end
                r.method_length = 13'(p_mlen);
                r.path_start    = 12'(pstart);
                r.path_length   = 13'(p_plen);
                r.query_present = p_qflag;
                r.query_start   = p_qflag ? 12'(pstart + p_plen + 1) : '0;
                r.query_length  = 13'(p_qlen);
                r.uri_length    = 13'(p_plen + (p_qflag ? 1 + p_qlen : 0));
                r.version_major = p_major;
                r.version_minor = p_minor;
            end
            expected_lines.push_back(r);
            clear_line_state();
        end
    endfunction

    // ------------------------------------------------------------------ clock

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // --------------------------------------------------------- result checker

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_line_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_lines.size() == 0) begin
                $error("result transaction with no line pending");
                mismatches++;
            end else begin
                want = expected_lines.pop_front();
                lines_checked++;
                if (m_axis_tuser) lines_valid++;
                check_field("line_valid",    want.line_valid,    m_axis_tuser);
                check_field("method_code",   want.method_code,   m_axis_tdata[3:0]);
                check_field("method_length", want.method_length, m_axis_tdata[16:4]);
                check_field("path_start",    want.path_start,    m_axis_tdata[28:17]);
                check_field("path_length",   want.path_length,   m_axis_tdata[41:29]);
                check_field("query_present", want.query_present, m_axis_tdata[42]);
                check_field("query_start",   want.query_start,   m_axis_tdata[54:43]);
                check_field("query_length",  want.query_length,  m_axis_tdata[67:55]);
                check_field("uri_length",    want.uri_length,    m_axis_tdata[80:68]);
                check_field("version_major", want.version_major, m_axis_tdata[84:81]);
                check_field("version_minor", want.version_minor, m_axis_tdata[88:85]);
            end
        end
    end

    // ------------------------------------------------------------ result sink

    initial begin : result_sink
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                // long hold-off so the parser fills up and stalls its input
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 14);
                m_axis_tready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // --------------------------------------------------------------- watchdog

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // -------------------------------------------------------------- stimulus

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 15) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_line_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line(input t_bytes q);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    function automatic t_bytes text_bytes(input string s);
        t_bytes q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic void append_text(ref t_bytes q, input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    function automatic void append_fill(ref t_bytes q, input logic [7:0] b, input int n);
        repeat (n) q.push_back(b);
    endfunction

    function automatic logic [7:0] random_letter();
        return $urandom_range(0, 1) ? 8'("A" + $urandom_range(0, 25))
                                    : 8'("a" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_byte_except(input logic [7:0] x,
                                                      input logic [7:0] y);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == x || b == y);
        return b;
    endfunction

    // mostly well-formed lines with random content, some damaged, some noise
    function automatic t_bytes random_line();
        t_bytes q;
        string  name;
        int     n;
        int     pos;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 24);
            repeat (n) q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        name = method_names[$urandom_range(0, NUM_NAMES - 1)];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: append_text(q, name);
            6: begin
                // extension that starts with a known name
                append_text(q, name);
                repeat ($urandom_range(1, 3)) q.push_back(random_letter());
            end
            7: repeat ($urandom_range(1, 8)) q.push_back(random_letter());
            8: ;
            default: begin
                append_text(q, name);
                pos = $urandom_range(0, name.len() - 1);
                q[pos] = q[pos] ^ 8'h20;
            end
        endcase
        q.push_back(CH_SPACE);
        repeat ($urandom_range(0, 10)) q.push_back(random_byte_except(CH_SPACE, CH_QMARK));
        if ($urandom_range(0, 1)) begin
            q.push_back(CH_QMARK);
            repeat ($urandom_range(0, 8)) q.push_back(random_byte_except(CH_SPACE, CH_SPACE));
        end
        append_text(q, version_text);
        q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        q.push_back(CH_DOT);
        q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
                1: begin
                    n = $urandom_range(1, q.size() - 1);
                    while (q.size() > n) void'(q.pop_back());
                end
                default: repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        return q;
    endfunction

    task automatic test_directed_lines();
        string  lines [$];
        t_bytes q;
        lines = '{
            "OPTIONS * HTTP/1.1", "GET / HTTP/1.1", "POST /form HTTP/1.0",
            "HEAD /x HTTP/1.1", "TRACE / HTTP/1.1", "PUT /f HTTP/1.1",
            "DELETE /f HTTP/1.1", "CONNECT h:443 HTTP/1.1", "POSTX / HTTP/1.1",
            "get / HTTP/1.1", "GE / HTTP/1.1", " / HTTP/0.0", "GET  HTTP/9.9",
            "GET /a?b=c HTTP/1.1", "GET /? HTTP/1.1", "GET /a?x?y HTTP/2.0",
            "GET / HTTP/1.1x", "GET / HTTP/1.1 ", "GET / HTTP/1.", "G3T / HTTP/1.1",
            "GET / HTTX/1.1", "GET / HTTP/a.1", "GET / HTTP/1,1", "GET / HTTP/1.z", "G"
        };
        foreach (lines[i]) send_line(text_bytes(lines[i]));
        // extreme byte values inside path and query
        q = text_bytes("GET /");
        q.push_back(8'h00);
        q.push_back(8'hFF);
        q.push_back(CH_QMARK);
        q.push_back(8'h80);
        q.push_back(8'h7F);
        append_text(q, " HTTP/1.1");
        send_line(q);
    endtask

    task automatic test_line_length_limit();
        t_bytes q;
        // exactly at the limit with the longest path after GET
        q = text_bytes("GET /");
        append_fill(q, "p", LINE_MAX - 14);
        append_text(q, " HTTP/1.1");
        send_line(q);
        // one byte over
        q = text_bytes("GET /");
        append_fill(q, "p", LINE_MAX - 13);
        append_text(q, " HTTP/1.1");
        send_line(q);
        // far over, position counter saturates
        q = text_bytes("GET /");
        append_fill(q, "p", LINE_MAX + 100);
        append_text(q, " HTTP/1.1");
        send_line(q);
        // longest method token with an empty path
        q = {};
        append_fill(q, "A", LINE_MAX - 10);
        append_text(q, "  HTTP/1.1");
        send_line(q);
        // longest query after GET /
        q = text_bytes("GET /?");
        append_fill(q, "q", LINE_MAX - 15);
        append_text(q, " HTTP/1.1");
        send_line(q);
    endtask

    task automatic test_output_backpressure();
        idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (6) send_line(text_bytes("PUT /a?b HTTP/1.1"));
        idle_on = 1'b1;
    endtask

    task automatic test_random_lines(input int byte_budget);
        int stop_at;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at) send_line(random_line());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        mismatches    = 0;
        lines_checked = 0;
        lines_valid   = 0;
        bytes_sent    = 0;
        clear_line_state();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_lines();
        test_line_length_limit();
        test_output_backpressure();
        test_random_lines(RANDOM_BYTES);
        idle_on = 1'b0;
        test_random_lines(RANDOM_BYTES / 6);

        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("covered %0d request lines (%0d accepted, %0d rejected) from %0d bytes,",
                 lines_checked, lines_valid, lines_checked - lines_valid, bytes_sent);
        $display("including length-limit lines, idle bursts and a long output hold-off");
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
